>>> rtl/multichannel_biquad_lowpass_defines.svh
// assertion macros shared by the checker
`ifndef MULTICHANNEL_BIQUAD_LOWPASS_DEFINES_SVH
`define MULTICHANNEL_BIQUAD_LOWPASS_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define MBQ_ASSERT_NOW(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error("mbq check failed");

// consequent checked in the cycle after the antecedent
`define MBQ_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error("mbq check failed");

`endif

>>> rtl/mbq_pkg.sv
package mbq_pkg;

	localparam int NUM_CHANNELS = 8;
	localparam int CH_W         = 3;
	localparam int DATA_W       = 24;
	localparam int COEF_W       = 32;
	localparam int FRAC_W       = 28;
	localparam int PROD_W       = COEF_W + DATA_W;
	localparam int ACC_W        = PROD_W + 4;
	localparam int HIST_AW      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
	localparam int ADDR_W       = 5;
	localparam int REG_IDX_W    = 3;

	localparam logic [REG_IDX_W-1:0] REG_B0 = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_B1 = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_B2 = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_A1 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_A2 = 3'd4;

	// butterworth low-pass, fs 1 khz, fc 10 hz
	localparam logic signed [COEF_W-1:0] B0_RST = 32'sd253590;
	localparam logic signed [COEF_W-1:0] B1_RST = 32'sd507179;
	localparam logic signed [COEF_W-1:0] B2_RST = 32'sd253590;
	localparam logic signed [COEF_W-1:0] A1_RST = -32'sd513033057;
	localparam logic signed [COEF_W-1:0] A2_RST = 32'sd245611955;

	typedef struct packed {
		logic [CH_W-1:0]          channel;
		logic signed [DATA_W-1:0] sample;
		logic                     in_range;
	} mbq_item_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
	} mbq_coef_t;

endpackage

>>> rtl/mbq_regs.sv
module mbq_regs import mbq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [COEF_W-1:0]   pwdata,
	output logic [COEF_W-1:0]   prdata,
	output logic                pready,
	output mbq_coef_t           coef
);

	mbq_coef_t              coef_q;
	logic [REG_IDX_W-1:0]   idx;
	logic                   wr_en;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign coef   = coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0 <= B0_RST;
			coef_q.b1 <= B1_RST;
			coef_q.b2 <= B2_RST;
			coef_q.a1 <= A1_RST;
			coef_q.a2 <= A2_RST;
		end else if (wr_en) begin
			case (idx)
				REG_B0: coef_q.b0 <= pwdata;
				REG_B1: coef_q.b1 <= pwdata;
				REG_B2: coef_q.b2 <= pwdata;
				REG_A1: coef_q.a1 <= pwdata;
				REG_A2: coef_q.a2 <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_B0:  prdata = coef_q.b0;
			REG_B1:  prdata = coef_q.b1;
			REG_B2:  prdata = coef_q.b2;
			REG_A1:  prdata = coef_q.a1;
			REG_A2:  prdata = coef_q.a2;
			default: prdata = '0;
		endcase
	end

endmodule

>>> rtl/mbq_front.sv
module mbq_front import mbq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     sample_valid,
	output logic                     sample_ready,
	input  logic [CH_W-1:0]          channel,
	input  logic signed [DATA_W-1:0] sample,
	output logic                     head_valid,
	output mbq_item_t                head,
	input  logic                     pop
);

	mbq_item_t             queue_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;
	logic                  push;
	mbq_item_t             item;

	assign sample_ready = (count_q != (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign push         = sample_valid && sample_ready;
	assign head_valid   = (count_q != '0);
	assign head         = queue_q[rd_ptr_q];

	// channels past the last one give a zero result and leave history alone
	always_comb begin
		item.channel  = channel;
		item.sample   = sample;
		item.in_range = (32'(channel) < NUM_CHANNELS);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/mbq_back.sv
module mbq_back import mbq_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      head_valid,
	input  mbq_item_t                 head,
	output logic                      pop,
	input  mbq_coef_t                 coef,
	output logic                      result_valid,
	input  logic                      result_ready,
	output logic [CH_W-1:0]           channel_out,
	output logic signed [DATA_W-1:0]  filtered
);

	localparam logic signed [ACC_W-1:0] Y_MAX  = ACC_W'((64'sd1 <<< (DATA_W-1)) - 1);
	localparam logic signed [ACC_W-1:0] Y_MIN  = -Y_MAX - 1;
	localparam logic signed [ACC_W-1:0] RND    = ACC_W'(64'sd1 <<< (FRAC_W-1));

	// per-channel history
	logic signed [DATA_W-1:0] xh1_q [NUM_CHANNELS];
	logic signed [DATA_W-1:0] xh2_q [NUM_CHANNELS];
	logic signed [DATA_W-1:0] yh1_q [NUM_CHANNELS];
	logic signed [DATA_W-1:0] yh2_q [NUM_CHANNELS];

	logic                     v_s1, v_s2, v_s3;
	logic [CH_W-1:0]          ch_s1, ch_s2, ch_s3;
	logic                     rng_s1, rng_s2, rng_s3;
	logic signed [DATA_W-1:0] x_s1, x1_s1, x2_s1, y1_s1, y2_s1;
	logic signed [DATA_W-1:0] x_s2, x1_s2, y1_s2;
	logic signed [DATA_W-1:0] x_s3, x1_s3, y1_s3;
	logic signed [PROD_W-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2;
	logic signed [ACC_W-1:0]  pb_s3, pa_s3;

	logic                     out_valid_q;
	logic [CH_W-1:0]          out_ch_q;
	logic signed [DATA_W-1:0] out_y_q;

	logic                     adv;
	logic                     hazard;
	logic [HIST_AW-1:0]       rd_idx;
	logic [HIST_AW-1:0]       wr_idx;
	logic signed [ACC_W-1:0]  acc;
	logic signed [ACC_W-1:0]  shf;
	logic signed [DATA_W-1:0] y_sat;

	assign adv    = !out_valid_q || result_ready;
	assign rd_idx = head.channel[HIST_AW-1:0];
	assign wr_idx = ch_s3[HIST_AW-1:0];

	// a channel still in flight has not written its history yet
	assign hazard = head.in_range && (
		(v_s1 && rng_s1 && ch_s1 == head.channel) ||
		(v_s2 && rng_s2 && ch_s2 == head.channel) ||
		(v_s3 && rng_s3 && ch_s3 == head.channel));
	assign pop = head_valid && adv && !hazard;

	// round half up at the binary point, then clamp
	always_comb begin
		acc = pb_s3 - pa_s3 + RND;
		shf = acc >>> FRAC_W;
		if (shf > Y_MAX) begin
			y_sat = Y_MAX[DATA_W-1:0];
		end else if (shf < Y_MIN) begin
			y_sat = Y_MIN[DATA_W-1:0];
		end else begin
			y_sat = shf[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= pop;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s1  <= head.channel;
			rng_s1 <= head.in_range;
			x_s1   <= head.sample;
			x1_s1  <= xh1_q[rd_idx];
			x2_s1  <= xh2_q[rd_idx];
			y1_s1  <= yh1_q[rd_idx];
			y2_s1  <= yh2_q[rd_idx];

			ch_s2  <= ch_s1;
			rng_s2 <= rng_s1;
			x_s2   <= x_s1;
			x1_s2  <= x1_s1;
			y1_s2  <= y1_s1;
			p0_s2  <= coef.b0 * x_s1;
			p1_s2  <= coef.b1 * x1_s1;
			p2_s2  <= coef.b2 * x2_s1;
			p3_s2  <= coef.a1 * y1_s1;
			p4_s2  <= coef.a2 * y2_s1;

			ch_s3  <= ch_s2;
			rng_s3 <= rng_s2;
			x_s3   <= x_s2;
			x1_s3  <= x1_s2;
			y1_s3  <= y1_s2;
			pb_s3  <= ACC_W'(p0_s2) + ACC_W'(p1_s2) + ACC_W'(p2_s2);
			pa_s3  <= ACC_W'(p3_s2) + ACC_W'(p4_s2);

			out_ch_q <= ch_s3;
			out_y_q  <= rng_s3 ? y_sat : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				xh1_q[i] <= '0;
				xh2_q[i] <= '0;
				yh1_q[i] <= '0;
				yh2_q[i] <= '0;
			end
		end else if (adv && v_s3 && rng_s3) begin
			xh1_q[wr_idx] <= x_s3;
			xh2_q[wr_idx] <= x1_s3;
			yh1_q[wr_idx] <= y_sat;
			yh2_q[wr_idx] <= y1_s3;
		end
	end

	assign result_valid = out_valid_q;
	assign channel_out  = out_ch_q;
	assign filtered     = out_y_q;

endmodule

>>> rtl/multichannel_biquad_lowpass.sv
// an accepted request is written to the queue and then passes stages s1, s2 and s3 and the
// output register; one request per cycle while results are taken and each channel differs
// from the three issued before it; a request on a channel still in the 3-stage multiply/sum
// pipeline waits at the queue head, so requests on one channel never overlap in the pipeline
// reset: coefficients return to the 10 hz butterworth set, all channel history to zero,
// the 4-entry request queue and the pipeline empty
module multichannel_biquad_lowpass import mbq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [COEF_W-1:0]        pwdata,
	output logic [COEF_W-1:0]        prdata,
	output logic                     pready,
	input  logic                     sample_valid,
	output logic                     sample_ready,
	input  logic [CH_W-1:0]          channel,
	input  logic signed [DATA_W-1:0] sample,
	output logic                     result_valid,
	input  logic                     result_ready,
	output logic [CH_W-1:0]          channel_out,
	output logic signed [DATA_W-1:0] filtered
);

	mbq_coef_t  coef;
	mbq_item_t  head;
	logic       head_valid;
	logic       pop;

	mbq_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coef    (coef)
	);

	mbq_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.channel      (channel),
		.sample       (sample),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop)
	);

	mbq_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.coef         (coef),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.channel_out  (channel_out),
		.filtered     (filtered)
	);

endmodule

>>> rtl/mbq_checker.sv
`include "multichannel_biquad_lowpass_defines.svh"

module mbq_checker import mbq_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     psel,
	input logic                     penable,
	input logic                     pwrite,
	input logic [ADDR_W-1:0]        paddr,
	input logic [COEF_W-1:0]        pwdata,
	input logic [COEF_W-1:0]        prdata,
	input logic                     pready,
	input logic                     sample_valid,
	input logic                     sample_ready,
	input logic [CH_W-1:0]          channel,
	input logic signed [DATA_W-1:0] sample,
	input logic                     result_valid,
	input logic                     result_ready,
	input logic [CH_W-1:0]          channel_out,
	input logic signed [DATA_W-1:0] filtered
);

	logic wr_b0;
	logic rd_b0;

	assign wr_b0 = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_B0);
	assign rd_b0 = psel && !pwrite && (paddr[ADDR_W-1:2] == REG_B0);

	// the register port never inserts wait states
	`MBQ_ASSERT_NOW(a_pready_high, 1'b1, pready)

	// a write to b0 reads back in the following cycle
	`MBQ_ASSERT_NOW(a_coef_readback, wr_b0 ##1 rd_b0, prdata == $past(pwdata))

	// a stalled result stays offered
	`MBQ_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid)

	`MBQ_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable(filtered) && $stable(channel_out))

endmodule

bind multichannel_biquad_lowpass mbq_checker u_mbq_checker (.*);

>>> tb/multichannel_biquad_lowpass_tb.sv
module multichannel_biquad_lowpass_tb;
	import mbq_pkg::*;

	localparam int NUM_GAINS     = int'(REG_A2) + 1;
	localparam int NUM_REG_SLOTS = 1 << REG_IDX_W;
	localparam int STALL_LIMIT   = 3000;
	localparam int DRAIN_CYCLES  = 24;
	localparam int LONG_HOLD     = 120;
	localparam int LONG_HOLD_AT  = 300;
	localparam int QUIET_FROM    = 1500;
	localparam int QUIET_TO      = 2100;

	localparam logic signed [DATA_W-1:0] SAMPLE_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAMPLE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [COEF_W-1:0] GAIN_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic signed [COEF_W-1:0] GAIN_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
	localparam logic signed [COEF_W-1:0] GAIN_HALF  = COEF_W'(1) << (FRAC_W-1);
	localparam longint ROUND_HALF = longint'(1) << (FRAC_W-1);
	localparam longint OUT_MAX    = longint'(SAMPLE_MAX);
	localparam longint OUT_MIN    = longint'(SAMPLE_MIN);

	// 10 hz butterworth at 1 khz, Q4.28
	localparam logic signed [COEF_W-1:0] BUTTERWORTH [NUM_GAINS] = '{
		32'sd253590, 32'sd507179, 32'sd253590, -32'sd513033057, 32'sd245611955
	};

	typedef enum int {SET_BUTTERWORTH, SET_FIR, SET_MODEST, SET_WILD} gain_set_t;

	typedef struct {
		logic [CH_W-1:0]          ch;
		logic signed [DATA_W-1:0] val;
	} chan_sample_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [ADDR_W-1:0]        paddr = '0;
	logic [COEF_W-1:0]        pwdata = '0;
	logic [COEF_W-1:0]        prdata;
	logic                     pready;
	logic                     sample_valid = 1'b0;
	logic                     sample_ready;
	logic [CH_W-1:0]          channel = '0;
	logic signed [DATA_W-1:0] sample = '0;
	logic                     result_valid;
	logic                     result_ready = 1'b0;
	logic [CH_W-1:0]          channel_out;
	logic signed [DATA_W-1:0] filtered;

	logic signed [COEF_W-1:0] gain [NUM_GAINS] = BUTTERWORTH;
	logic signed [DATA_W-1:0] x_prev1 [NUM_CHANNELS] = '{default: '0};
	logic signed [DATA_W-1:0] x_prev2 [NUM_CHANNELS] = '{default: '0};
	logic signed [DATA_W-1:0] y_prev1 [NUM_CHANNELS] = '{default: '0};
	logic signed [DATA_W-1:0] y_prev2 [NUM_CHANNELS] = '{default: '0};

	chan_sample_t pending_reqs [$];
	chan_sample_t expected_outputs [$];
	int           mismatches = 0;
	int           results_seen = 0;
	int           cyc = 0;
	int           stall_cycles = 0;
	int           hold_left = 0;
	bit           long_hold_done = 1'b0;
	bit           quiet;

	multichannel_biquad_lowpass i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.channel      (channel),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.channel_out  (channel_out),
		.filtered     (filtered)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	assign quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

	// direct form one with round-half-up at the Q4.28 point, then 24-bit saturation
	function automatic logic signed [DATA_W-1:0] biquad_predict(
		input logic [CH_W-1:0] ch, input logic signed [DATA_W-1:0] x);
		longint acc;
		longint y;
		if (int'(ch) >= NUM_CHANNELS)
			return '0;
		acc = longint'(gain[REG_B0]) * longint'(x)
			+ longint'(gain[REG_B1]) * longint'(x_prev1[ch])
			+ longint'(gain[REG_B2]) * longint'(x_prev2[ch])
			- longint'(gain[REG_A1]) * longint'(y_prev1[ch])
			- longint'(gain[REG_A2]) * longint'(y_prev2[ch]);
		y = (acc + ROUND_HALF) >>> FRAC_W;
		if (y > OUT_MAX)
			y = OUT_MAX;
		else if (y < OUT_MIN)
			y = OUT_MIN;
		x_prev2[ch] = x_prev1[ch];
		x_prev1[ch] = x;
		y_prev2[ch] = y_prev1[ch];
		y_prev1[ch] = DATA_W'(y);
		return DATA_W'(y);
	endfunction

	task automatic write_gain(input logic [REG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		// writes above the last coefficient are dropped by the block
		if (idx <= REG_A2)
			gain[idx] = val;
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_reqs.size() != 0 || sample_valid || expected_outputs.size() != 0);
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_requests
		chan_sample_t nxt;
		if (!arst_n) begin
			sample_valid <= 1'b0;
			channel      <= '0;
			sample       <= '0;
		end else if (!sample_valid || sample_ready) begin
			if (pending_reqs.size() != 0 && (quiet || $urandom_range(0, 99) >= 35)) begin
				nxt = pending_reqs.pop_front();
				sample_valid <= 1'b1;
				channel      <= nxt.ch;
				sample       <= nxt.val;
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : check_results
		chan_sample_t exp_r;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (sample_valid && sample_ready)
				expected_outputs.push_back('{channel, biquad_predict(channel, sample)});
			if (result_valid && result_ready) begin
				results_seen++;
				if (expected_outputs.size() == 0) begin
					$error("unexpected result: channel_out %0d filtered %0d",
						channel_out, filtered);
					mismatches++;
				end else begin
					exp_r = expected_outputs.pop_front();
					if (channel_out !== exp_r.ch) begin
						$error("channel_out: expected %0d, got %0d", exp_r.ch, channel_out);
						mismatches++;
					end
					if (filtered !== exp_r.val) begin
						$error("filtered: expected %0d, got %0d", exp_r.val, filtered);
						mismatches++;
					end
				end
			end
			// long hold-off so the request queue backs up and input stalls
			if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end else if (hold_left == 0 && !quiet && $urandom_range(0, 499) == 0) begin
				hold_left = $urandom_range(10, 40);
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= quiet || ($urandom_range(0, 99) >= 35);
			end
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if ((sample_valid && sample_ready) || (result_valid && result_ready) || psel || !arst_n) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("multichannel_biquad_lowpass: mismatch");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin : run_phases
		gain_set_t plan [5];
		int        plan_items [5];
		logic signed [COEF_W-1:0] w;
		logic signed [DATA_W-1:0] s;
		logic [CH_W-1:0] ch;

		plan       = '{SET_BUTTERWORTH, SET_FIR, SET_MODEST, SET_WILD, SET_BUTTERWORTH};
		plan_items = '{600, 400, 350, 150, 300};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset gains: full-scale steps on every channel
		for (int c = 0; c < NUM_CHANNELS; c++)
			pending_reqs.push_back('{CH_W'(c), (c % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN});
		wait_drained();

		// pass-through at one half: odd samples land exactly on the rounding tie
		write_gain(REG_B0, GAIN_HALF);
		write_gain(REG_B1, '0);
		write_gain(REG_B2, '0);
		write_gain(REG_A1, '0);
		write_gain(REG_A2, '0);
		pending_reqs.push_back('{CH_W'(0), 24'sd1});
		pending_reqs.push_back('{CH_W'(0), -24'sd1});
		pending_reqs.push_back('{CH_W'(0), 24'sd3});
		pending_reqs.push_back('{CH_W'(0), -24'sd3});
		pending_reqs.push_back('{CH_W'(0), 24'sd0});
		wait_drained();

		// extreme gains, both saturation rails, and writes to unused slots
		write_gain(REG_B0, GAIN_MAX);
		write_gain(REG_B1, GAIN_MIN);
		write_gain(REG_B2, GAIN_MAX);
		write_gain(REG_A1, GAIN_MIN);
		write_gain(REG_A2, GAIN_MAX);
		for (int idx = NUM_GAINS; idx < NUM_REG_SLOTS; idx++)
			write_gain(REG_IDX_W'(idx), $urandom);
		for (int k = 0; k < 4; k++) begin
			pending_reqs.push_back('{CH_W'(1), (k % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN});
			pending_reqs.push_back('{CH_W'(NUM_CHANNELS-2), (k % 2 == 0) ? SAMPLE_MIN : SAMPLE_MAX});
		end
		wait_drained();

		for (int p = 0; p < 5; p++) begin
			for (int idx = 0; idx < NUM_GAINS; idx++) begin
				case (plan[p])
					SET_BUTTERWORTH: w = BUTTERWORTH[idx];
					SET_FIR: w = (idx <= int'(REG_B2)) ? ($urandom_range(0, 1 << 28) - (1 << 27)) : '0;
					SET_MODEST: w = $urandom_range(0, 1 << 29) - (1 << 28);
					default: w = $urandom;
				endcase
				write_gain(REG_IDX_W'(idx), w);
			end
			for (int n = 0; n < plan_items[p]; n++) begin
				ch = CH_W'($urandom_range(0, NUM_CHANNELS-1));
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: s = DATA_W'($urandom);
					5, 6: s = DATA_W'($urandom_range(0, 2000) - 1000);
					7: s = SAMPLE_MAX;
					8: s = SAMPLE_MIN;
					default: s = DATA_W'($urandom_range(0, 255));
				endcase
				pending_reqs.push_back('{ch, s});
			end
			// sender pauses here until the block has handed back everything
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_outputs.size() == 0)
			$display("multichannel_biquad_lowpass: match");
		else
			$display("multichannel_biquad_lowpass: mismatch");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/mbq_pkg.sv
rtl/mbq_regs.sv
rtl/mbq_front.sv
rtl/mbq_back.sv
rtl/multichannel_biquad_lowpass.sv
rtl/mbq_checker.sv
tb/multichannel_biquad_lowpass_tb.sv
